@@ hw/rtl/dre_pkg.sv @@
// ---------------------------------------------------------------------------
// dre_pkg
// Shared types and codes for the debounced rotary encoder counter.
// ---------------------------------------------------------------------------
package dre_pkg;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    localparam int LIMIT_W = 8;
    localparam int POS_W   = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd10;

    typedef struct packed {
        logic                    opcode;
        logic                    pin_a;
        logic                    pin_b;
        logic signed [POS_W-1:0] load_value;
    } dre_in_t;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic                    stable_a;
        logic                    stable_b;
        logic                    stepped;
        logic                    step_up;
    } dre_out_t;

    typedef struct packed {
        logic stable_a;
        logic stable_b;
        logic rise_a;
    } dre_deb_status_t;

endpackage

@@ hw/rtl/dre_debounce.sv @@
// ---------------------------------------------------------------------------
// dre_debounce
// Two-channel pin debouncer with rising-edge detect on debounced channel A.
// ---------------------------------------------------------------------------
module dre_debounce (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           fire,
    input  logic                           pin_a,
    input  logic                           pin_b,
    input  logic [dre_pkg::LIMIT_W-1:0]    limit,
    output dre_pkg::dre_deb_status_t       status
);
    import dre_pkg::*;

    logic [1:0]         last_raw_reg;
    logic [1:0]         last_raw_next;
    logic [LIMIT_W-1:0] count_reg;
    logic [LIMIT_W-1:0] count_next;
    logic [1:0]         debounced_reg;
    logic [1:0]         debounced_next;
    logic [1:0]         prior_reg;
    logic [1:0]         sample;

    assign sample = {~pin_b, ~pin_a};

    always_comb
    begin
        last_raw_next  = last_raw_reg;
        count_next     = count_reg;
        debounced_next = debounced_reg;
        if (sample == last_raw_reg)
        begin
            if (count_reg >= limit)
            begin
                debounced_next = sample;
            end
            else
            begin
                count_next = count_reg + LIMIT_W'(1);
            end
        end
        else
        begin
            count_next    = '0;
            last_raw_next = sample;
        end
    end

    always_comb
    begin
        status.stable_a = fire ? debounced_next[0] : debounced_reg[0];
        status.stable_b = fire ? debounced_next[1] : debounced_reg[1];
        status.rise_a   = fire & debounced_next[0] & ~prior_reg[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg  <= '0;
            count_reg     <= '0;
            debounced_reg <= '0;
            prior_reg     <= '0;
        end
        else if (fire)
        begin
            last_raw_reg  <= last_raw_next;
            count_reg     <= count_next;
            debounced_reg <= debounced_next;
            prior_reg     <= debounced_next;
        end
    end

`ifndef SYNTH
    a_prior_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        prior_reg == debounced_reg)
        else $error("prior debounced state diverged");

    a_change_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (sample != last_raw_reg) |=> count_reg == '0)
        else $error("raw change did not restart the count");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(debounced_reg) && $stable(count_reg))
        else $error("debounce state moved without a sample");

    a_rise_sets_a: assert property (@(posedge clk) disable iff (!rst_n)
        status.rise_a |=> debounced_reg[0] && !$past(debounced_reg[0]))
        else $error("edge flagged without debounced A rising");
`endif

endmodule

@@ hw/rtl/debounced_rotary_encoder_counter_unit.sv @@
// ---------------------------------------------------------------------------
// debounced_rotary_encoder_counter_unit
// Debounces active-low quadrature pins and keeps a signed 16-bit position.
// ---------------------------------------------------------------------------
// channel  | handshake             | payload
// in       | in_valid / in_ready   | in_data  (dre_in_t)
// out      | out_valid / out_ready | out_data (dre_out_t)
// cfg      | cfg_valid / cfg_ready | cfg_data (debounce limit, 8 bits)
//
// One item per cycle unless the output stalls; its result is in the output
// register from the cycle after acceptance. in_ready is high when the output
// register is empty or being drained, so a stalled output holds input off.
// Reset clears all pin state (pins inactive), the position, and sets the
// debounce limit to 10. cfg_ready is always high.
// ---------------------------------------------------------------------------
module debounced_rotary_encoder_counter_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  dre_pkg::dre_in_t            in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output dre_pkg::dre_out_t           out_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [dre_pkg::LIMIT_W-1:0] cfg_data
);
    import dre_pkg::*;

    logic [LIMIT_W-1:0]      limit_reg;
    logic signed [POS_W-1:0] pos_reg;
    logic signed [POS_W-1:0] pos_next;
    logic                    out_valid_reg;
    dre_out_t                out_data_reg;
    dre_out_t                out_data_next;
    dre_deb_status_t         deb_status;
    logic                    accept;
    logic                    fire;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign fire      = accept && (in_data.opcode == OP_SAMPLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    dre_debounce u_debounce (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .pin_a  (in_data.pin_a),
        .pin_b  (in_data.pin_b),
        .limit  (limit_reg),
        .status (deb_status)
    );

    always_comb
    begin
        pos_next = pos_reg;
        if (in_data.opcode == OP_LOAD)
        begin
            pos_next = in_data.load_value;
        end
        else if (deb_status.rise_a)
        begin
            pos_next = deb_status.stable_b ? pos_reg + POS_W'(1) : pos_reg - POS_W'(1);
        end
        out_data_next.position = pos_next;
        out_data_next.stable_a = deb_status.stable_a;
        out_data_next.stable_b = deb_status.stable_b;
        out_data_next.stepped  = deb_status.rise_a;
        out_data_next.step_up  = deb_status.rise_a & deb_status.stable_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
            if (accept)
            begin
                pos_reg       <= pos_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTH
    a_out_matches_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_data_reg.position == pos_reg)
        else $error("held result position differs from counter");

    a_step_moves_pos: assert property (@(posedge clk) disable iff (!rst_n)
        fire && deb_status.rise_a |=> pos_reg != $past(pos_reg))
        else $error("step did not move the position");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_data_reg))
        else $error("stalled result changed");
`endif

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Testbench for debounced_rotary_encoder_counter_unit
// Sends pin samples and position loads through the input channel and checks
// each result, field by field, against a cycle-free encoder model that runs
// as items are accepted. It covers several debounce limits (reset value,
// zero, full scale, one and a random small value), position wrap both ways,
// quadrature rotation with contact bounce, and random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
    import dre_pkg::*;

    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 6;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    dre_in_t             in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    dre_out_t            out_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [LIMIT_W-1:0]  cfg_data  = '0;

    dre_in_t             pending_items[$];
    dre_out_t            expected_results[$];
    int                  error_count = 0;
    int                  quiet_cycles = 0;
    bit                  idle_on = 1'b1;
    int                  send_hold = 0;
    int                  ready_hold = 0;

    logic [LIMIT_W-1:0]  enc_limit = LIMIT_RESET;
    logic [1:0]          enc_last_raw = '0;
    logic [LIMIT_W-1:0]  enc_count = '0;
    logic [1:0]          enc_stable = '0;
    logic [1:0]          enc_prev = '0;
    logic signed [POS_W-1:0] enc_position = '0;

    debounced_rotary_encoder_counter_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic dre_out_t predict_encoder(input dre_in_t item);
        dre_out_t   res;
        logic [1:0] sample;
        logic [1:0] rise;
        res = '0;
        if (item.opcode == OP_LOAD)
        begin
            enc_position = item.load_value;
        end
        else
        begin
            sample = {~item.pin_b, ~item.pin_a};
            if (sample == enc_last_raw)
            begin
                if (enc_count >= enc_limit)
                    enc_stable = sample;
                else
                    enc_count = enc_count + 1'b1;
            end
            else
            begin
                enc_count    = '0;
                enc_last_raw = sample;
            end
            rise     = enc_stable & ~enc_prev;
            enc_prev = enc_stable;
            if (rise[0])
            begin
                res.stepped = 1'b1;
                if (enc_stable[1])
                begin
                    res.step_up  = 1'b1;
                    enc_position = enc_position + POS_W'(1);
                end
                else
                begin
                    enc_position = enc_position - POS_W'(1);
                end
            end
        end
        res.position = enc_position;
        res.stable_a = enc_stable[0];
        res.stable_b = enc_stable[1];
        return res;
    endfunction

    function automatic int pick_gap();
        if (!idle_on)
            return 0;
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        error_count++;
    endtask

    task automatic add_sample(input bit a_act, input bit b_act);
        dre_in_t item;
        item.opcode     = OP_SAMPLE;
        item.pin_a      = ~a_act;
        item.pin_b      = ~b_act;
        item.load_value = POS_W'($urandom);
        pending_items.push_back(item);
    endtask

    task automatic add_load(input logic signed [POS_W-1:0] value);
        dre_in_t item;
        item.opcode     = OP_LOAD;
        item.pin_a      = 1'($urandom);
        item.pin_b      = 1'($urandom);
        item.load_value = value;
        pending_items.push_back(item);
    endtask

    // quadrature phase q: 0 = none, 1 = B, 2 = A and B, 3 = A; q+1 counts up
    task automatic add_random_phase(input int budget, input int lim);
        int       start;
        int       pick;
        int       hold;
        bit       up_dir;
        bit [1:0] q;
        bit [1:0] q_old;
        start  = pending_items.size();
        up_dir = 1'b1;
        q      = 2'd0;
        while (pending_items.size() - start < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                case ($urandom_range(0, 5))
                    0: add_load(16'sh7FFF);
                    1: add_load(16'sh8000);
                    2: add_load(16'sh0000);
                    default: add_load(POS_W'($urandom));
                endcase
            end
            else if (pick < 18)
            begin
                repeat ($urandom_range(1, 6))
                    add_sample(1'($urandom), 1'($urandom));
            end
            else
            begin
                if ($urandom_range(0, 99) < 15)
                    up_dir = ~up_dir;
                q_old = q;
                q     = up_dir ? q + 2'd1 : q - 2'd1;
                repeat ($urandom_range(0, 3))
                begin
                    add_sample(q[1], q[1] ^ q[0]);
                    add_sample(q_old[1], q_old[1] ^ q_old[0]);
                end
                hold = lim + 1 + $urandom_range(0, 4);
                repeat (hold)
                    add_sample(q[1], q[1] ^ q[0]);
            end
        end
    endtask

    task automatic settle();
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        enc_limit = value;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_results.push_back(predict_encoder(in_data));
            if (!in_valid || in_ready)
            begin
                if (send_hold > 0)
                begin
                    send_hold--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_items.pop_front();
                    if ($urandom_range(0, 99) < 30)
                        send_hold = pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        dre_out_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result, position %0d",
                                              out_data.position));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.position !== want.position)
                        report_mismatch($sformatf("position got %0d want %0d",
                                                  out_data.position, want.position));
                    if (out_data.stable_a !== want.stable_a)
                        report_mismatch($sformatf("stable_a got %b want %b",
                                                  out_data.stable_a, want.stable_a));
                    if (out_data.stable_b !== want.stable_b)
                        report_mismatch($sformatf("stable_b got %b want %b",
                                                  out_data.stable_b, want.stable_b));
                    if (out_data.stepped !== want.stepped)
                        report_mismatch($sformatf("stepped got %b want %b",
                                                  out_data.stepped, want.stepped));
                    if (out_data.step_up !== want.step_up)
                        report_mismatch($sformatf("step_up got %b want %b",
                                                  out_data.step_up, want.step_up));
                end
            end
            if (ready_hold > 0)
            begin
                ready_hold--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 99) < 20)
                    ready_hold = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("debounced_rotary_encoder_counter_unit test failed");
        $finish;
    end

    initial
    begin
        logic [LIMIT_W-1:0] lim;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        add_load(16'sh7FFF);
        add_load(16'sh8000);
        add_load(16'shFFFF);
        add_load(16'sh0000);
        add_random_phase(280, LIMIT_RESET);
        settle();

        // zero limit: step across both wrap points without idling
        idle_on = 1'b0;
        write_limit(8'd0);
        add_sample(1'b0, 1'b0);
        add_sample(1'b0, 1'b0);
        add_load(16'sh7FFF);
        add_sample(1'b1, 1'b1);
        add_sample(1'b1, 1'b1);
        add_sample(1'b0, 1'b0);
        add_sample(1'b0, 1'b0);
        add_load(16'sh8000);
        add_sample(1'b1, 1'b0);
        add_sample(1'b1, 1'b0);
        add_sample(1'b0, 1'b1);
        add_sample(1'b0, 1'b1);
        add_sample(1'b1, 1'b1);
        add_sample(1'b1, 1'b1);
        add_load(16'sh0000);
        add_random_phase(320, 0);
        settle();

        idle_on = 1'b1;
        write_limit(8'd255);
        add_random_phase(650, 255);
        settle();

        write_limit(8'd1);
        add_random_phase(250, 1);
        settle();

        lim = LIMIT_W'($urandom_range(2, 20));
        write_limit(lim);
        add_random_phase(250, lim);
        settle();

        if (error_count == 0)
            $display("debounced_rotary_encoder_counter_unit test passed");
        else
            $display("debounced_rotary_encoder_counter_unit test failed");
        $finish;
    end
endmodule
